// ===== hw/rtl/ssl_pkg.sv =====
// shared types, constants and elaboration helpers for the setpoint step limiter
package ssl_pkg;

    localparam int CoordW    = 24;
    localparam int StepW     = 23;
    localparam int DivSteps  = 24;
    localparam int SqrtSteps = 25;
    localparam int SqrtTop   = 48;
    localparam int CntW      = 5;

    typedef logic signed [CoordW-1:0] coord_t;

    localparam coord_t CoordMax = 24'sh7FFFFF;
    localparam coord_t CoordMin = 24'sh800000;

    typedef enum logic [2:0] {
        REG_MAX_XY = 3'd0,
        REG_MAX_Z  = 3'd1,
        REG_X_UP   = 3'd2,
        REG_Y_UP   = 3'd3,
        REG_Z_UP   = 3'd4,
        REG_X_LO   = 3'd5,
        REG_Y_LO   = 3'd6,
        REG_Z_LO   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [StepW-1:0]  max_xy;
        logic [StepW-1:0]  max_z;
        logic [2:0][CoordW-1:0] upper;
        logic [2:0][CoordW-1:0] lower;
    } cfg_t;

    function automatic longint unsigned fade_pow(input int base, input int p);
        longint unsigned w;
        w = 1;
        for (int i = 0; i < p; i++)
        begin
            w = w * longint'(base);
        end
        return w;
    endfunction

    function automatic longint unsigned fade_wsum(input int n, input int p);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < n; i++)
        begin
            s = s + fade_pow(n - i, p);
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/ssl_cmpsub.sv =====
// shared compare and subtract unit used by the root and divide steps and the step length check
module ssl_cmpsub #(
    parameter int W = 50
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         ge,
    output logic [W-1:0] diff
);
    assign ge   = (a >= b);
    assign diff = a - b;
endmodule

// ===== hw/rtl/ssl_hist.sv =====
// history memory of limited targets, one write and one registered read port
module ssl_hist #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 72
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] hist_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[waddr] <= wdata;
        end
        rdata_reg <= hist_mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/ssl_core.sv =====
// sequencer and datapath: step limit, history push, faded average, box clamp
module ssl_core #(
    parameter int DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssl_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ssl_pkg::coord_t [2:0] pos,
    input  ssl_pkg::coord_t [2:0] goal,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ssl_pkg::coord_t [2:0] safe
);
    import ssl_pkg::*;

    localparam longint unsigned WSUM5 = fade_wsum(DEPTH, 5);
    localparam longint unsigned WSUM2 = fade_wsum(DEPTH, 2);
    localparam longint unsigned HALF5 = WSUM5 / 2;
    localparam longint unsigned HALF2 = WSUM2 / 2;
    localparam int WSW  = $clog2(WSUM5 + 1);
    localparam int WW   = $clog2(fade_pow(DEPTH, 5) + 1);
    localparam int ACCW = CoordW + WSW;
    localparam int DENW = (WSW > 26) ? WSW : 26;
    localparam int CW   = (ACCW > DENW + DivSteps) ? ACCW : DENW + DivSteps;
    localparam int MA   = (WW > 25) ? WW : 25;
    localparam int MB   = 25;
    localparam int PW   = MA + MB;
    localparam int TW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW   = $clog2(DEPTH + 1);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_SQR  = 20'h00002,
        S_SQA  = 20'h00004,
        S_LM0  = 20'h00008,
        S_LM1  = 20'h00010,
        S_LM2  = 20'h00020,
        S_LL   = 20'h00040,
        S_LC   = 20'h00080,
        S_SCM  = 20'h00100,
        S_SCD  = 20'h00200,
        S_PUSH = 20'h00400,
        S_TRD  = 20'h00800,
        S_TX   = 20'h01000,
        S_TY   = 20'h02000,
        S_TZ   = 20'h04000,
        S_TA   = 20'h08000,
        S_AVG  = 20'h10000,
        S_DONE = 20'h20000,
        S_DIV  = 20'h40000,
        S_SQRT = 20'h80000
    } state_t;

    typedef enum logic [2:0] {
        J_HL  = 3'd0,
        J_LIM = 3'd1,
        J_LEN = 3'd2,
        J_SC  = 3'd3,
        J_AVG = 3'd4
    } job_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic [1:0]    k_reg, k_next;
    logic [TW-1:0] tap_reg, tap_next;
    logic [TW-1:0] rp_reg, rp_next;
    logic [TW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    coord_t [2:0]  pos_reg, pos_next;
    coord_t [2:0]  tgt_reg, tgt_next;
    coord_t [2:0]  res_reg, res_next;
    coord_t [2:0]  safe_reg, safe_next;
    logic [2:0][CoordW-1:0] dabs_reg, dabs_next;
    logic [2:0]    dneg_reg, dneg_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic [CW-1:0] tsq_reg, tsq_next;
    logic [24:0]   hl_reg, hl_next;
    logic [24:0]   len_reg, len_next;
    logic [StepW-1:0] lim_reg, lim_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] dsh_reg, dsh_next;
    logic [CW-1:0] quo_reg, quo_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [2:0][ACCW-1:0] acc_reg, acc_next;
    logic          vneg_reg, vneg_next;
    logic          out_valid_reg, out_valid_next;

    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [CW-1:0] cs_a, cs_b, cs_diff;
    logic          cs_ge;
    logic [CW-1:0] eng_q;
    logic          hist_we;
    logic [3*CoordW-1:0] hist_rdata;
    logic signed [24:0] din [3];
    logic          use_hist;
    logic [WW-1:0] w5_tab [DEPTH];
    logic [WW-1:0] w2_tab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_wtab
        assign w5_tab[g] = WW'(fade_pow(DEPTH - g, 5));
        assign w2_tab[g] = WW'(fade_pow(DEPTH - g, 2));
    end

    function automatic coord_t scale_tgt(input coord_t p, input logic neg,
                                         input logic [CoordW-1:0] q);
        logic signed [25:0] s;
        logic signed [25:0] qs;
        qs = $signed({2'b00, q});
        s  = $signed({{2{p[CoordW-1]}}, p}) + (neg ? -qs : qs);
        if (s > 26'sd8388607)
        begin
            return CoordMax;
        end
        else if (s < -26'sd8388608)
        begin
            return CoordMin;
        end
        return s[CoordW-1:0];
    endfunction

    function automatic coord_t clamp_axis(input logic signed [24:0] v,
                                          input logic [CoordW-1:0] lo,
                                          input logic [CoordW-1:0] up);
        logic signed [24:0] l25;
        logic signed [24:0] u25;
        logic signed [24:0] a;
        l25 = $signed({lo[CoordW-1], lo});
        u25 = $signed({up[CoordW-1], up});
        a   = (v > l25) ? v : l25;
        return (a < u25) ? a[CoordW-1:0] : up;
    endfunction

    function automatic logic [CoordW-1:0] abs_coord(input logic [CoordW-1:0] v);
        return v[CoordW-1] ? (~v + 1'b1) : v;
    endfunction

    ssl_cmpsub #(.W(CW)) u_cmpsub (
        .a    (cs_a),
        .b    (cs_b),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    ssl_hist #(.DEPTH(DEPTH), .WIDTH(3 * CoordW)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (tgt_reg),
        .raddr (rp_reg),
        .rdata (hist_rdata)
    );

    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign use_hist = (FW'(tap_reg) < fill_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign safe      = safe_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            din[i] = $signed({goal[i][CoordW-1], goal[i]})
                   - $signed({pos[i][CoordW-1], pos[i]});
        end
    end

    // operands of the shared compare unit
    always_comb
    begin
        cs_a = rem_reg;
        cs_b = dsh_reg;
        case (state_reg)
            S_SQRT:
            begin
                cs_b = quo_reg + dsh_reg;
            end
            S_LC:
            begin
                cs_a = CW'(prod_reg);
                cs_b = tsq_reg;
            end
            default:
            begin
                cs_b = dsh_reg;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            eng_q = cs_ge ? ((quo_reg >> 1) + dsh_reg) : (quo_reg >> 1);
        end
        else
        begin
            eng_q = {quo_reg[CW-2:0], cs_ge};
        end
    end

    always_comb
    begin
        logic [CoordW-1:0] hv;
        logic [ACCW-1:0]   pext;
        logic [ACCW-1:0]   aabs;
        logic signed [24:0] av;
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        tap_next   = tap_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        res_next   = res_reg;
        safe_next  = safe_reg;
        dabs_next  = dabs_reg;
        dneg_next  = dneg_reg;
        sum_next   = sum_reg;
        tsq_next   = tsq_reg;
        hl_next    = hl_reg;
        len_next   = len_reg;
        lim_next   = lim_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        vneg_next  = vneg_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        mul_a   = '0;
        mul_b   = '0;
        hist_we = 1'b0;
        hv      = '0;
        pext    = ACCW'(prod_reg);
        aabs    = '0;
        av      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dneg_next[i] = din[i][24];
                        dabs_next[i] = din[i][24] ? CoordW'(-din[i]) : CoordW'(din[i]);
                    end
                    pos_next = pos;
                    tgt_next = goal;
                    k_next   = '0;
                    sum_next = '0;
                    if ((din[0] != 0) || (din[1] != 0) || (din[2] != 0))
                    begin
                        state_next = S_SQR;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_SQR:
            begin
                mul_a      = MA'(dabs_reg[k_reg]);
                mul_b      = MB'(dabs_reg[k_reg]);
                prod_next  = mul_p;
                state_next = S_SQA;
            end
            S_SQA:
            begin
                if (k_reg == 2'd2)
                begin
                    tsq_next   = sum_reg + CW'(prod_reg);
                    rem_next   = sum_reg;
                    quo_next   = '0;
                    dsh_next   = CW'(1) << SqrtTop;
                    cnt_next   = CntW'(SqrtSteps - 1);
                    job_next   = J_HL;
                    state_next = S_SQRT;
                end
                else
                begin
                    sum_next   = sum_reg + CW'(prod_reg);
                    k_next     = k_reg + 2'd1;
                    state_next = S_SQR;
                end
            end
            S_LM0:
            begin
                mul_a      = MA'(hl_reg);
                mul_b      = MB'(cfg.max_xy);
                prod_next  = mul_p;
                state_next = S_LM1;
            end
            S_LM1:
            begin
                sum_next   = CW'(prod_reg);
                mul_a      = MA'(dabs_reg[2]);
                mul_b      = MB'(cfg.max_z);
                prod_next  = mul_p;
                state_next = S_LM2;
            end
            S_LM2:
            begin
                rem_next   = sum_reg + CW'(prod_reg);
                dsh_next   = CW'(CW'(hl_reg) + CW'(dabs_reg[2])) << (DivSteps - 1);
                quo_next   = '0;
                cnt_next   = CntW'(DivSteps - 1);
                job_next   = J_LIM;
                state_next = S_DIV;
            end
            S_LL:
            begin
                mul_a      = MA'(lim_reg);
                mul_b      = MB'(lim_reg);
                prod_next  = mul_p;
                state_next = S_LC;
            end
            S_LC:
            begin
                if (cs_ge)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    rem_next   = tsq_reg;
                    quo_next   = '0;
                    dsh_next   = CW'(1) << SqrtTop;
                    cnt_next   = CntW'(SqrtSteps - 1);
                    job_next   = J_LEN;
                    state_next = S_SQRT;
                end
            end
            S_SCM:
            begin
                mul_a      = MA'(dabs_reg[k_reg]);
                mul_b      = MB'(lim_reg);
                prod_next  = mul_p;
                state_next = S_SCD;
            end
            S_SCD:
            begin
                rem_next   = CW'(prod_reg);
                dsh_next   = CW'(len_reg) << (DivSteps - 1);
                quo_next   = '0;
                cnt_next   = CntW'(DivSteps - 1);
                job_next   = J_SC;
                state_next = S_DIV;
            end
            S_PUSH:
            begin
                hist_we  = 1'b1;
                rp_next  = wp_reg;
                wp_next  = (wp_reg == TW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FW'(DEPTH))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                tap_next   = '0;
                acc_next   = '0;
                state_next = S_TRD;
            end
            S_TRD:
            begin
                state_next = S_TX;
            end
            S_TX, S_TY, S_TZ:
            begin
                if (state_reg == S_TX)
                begin
                    hv = use_hist ? hist_rdata[CoordW-1:0] : pos_reg[0];
                    mul_a = MA'(w5_tab[tap_reg]);
                    state_next = S_TY;
                end
                else if (state_reg == S_TY)
                begin
                    hv = use_hist ? hist_rdata[2*CoordW-1:CoordW] : pos_reg[1];
                    mul_a = MA'(w5_tab[tap_reg]);
                    acc_next[0] = acc_reg[0] + (vneg_reg ? -pext : pext);
                    state_next = S_TZ;
                end
                else
                begin
                    hv = use_hist ? hist_rdata[3*CoordW-1:2*CoordW] : pos_reg[2];
                    mul_a = MA'(w2_tab[tap_reg]);
                    acc_next[1] = acc_reg[1] + (vneg_reg ? -pext : pext);
                    state_next = S_TA;
                end
                mul_b     = MB'(abs_coord(hv));
                vneg_next = hv[CoordW-1];
                prod_next = mul_p;
            end
            S_TA:
            begin
                acc_next[2] = acc_reg[2] + (vneg_reg ? -pext : pext);
                if (tap_reg == TW'(DEPTH - 1))
                begin
                    k_next     = '0;
                    state_next = S_AVG;
                end
                else
                begin
                    tap_next   = tap_reg + 1'b1;
                    rp_next    = (rp_reg == '0) ? TW'(DEPTH - 1) : rp_reg - 1'b1;
                    state_next = S_TRD;
                end
            end
            S_AVG:
            begin
                aabs = acc_reg[k_reg][ACCW-1] ? -acc_reg[k_reg] : acc_reg[k_reg];
                if (k_reg == 2'd2)
                begin
                    rem_next = CW'(aabs) + CW'(HALF2);
                    dsh_next = CW'(WSUM2) << (DivSteps - 1);
                end
                else
                begin
                    rem_next = CW'(aabs) + CW'(HALF5);
                    dsh_next = CW'(WSUM5) << (DivSteps - 1);
                end
                quo_next   = '0;
                cnt_next   = CntW'(DivSteps - 1);
                job_next   = J_AVG;
                state_next = S_DIV;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    safe_next      = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV, S_SQRT:
            begin
                if (cs_ge)
                begin
                    rem_next = cs_diff;
                end
                quo_next = eng_q;
                dsh_next = (state_reg == S_SQRT) ? (dsh_reg >> 2) : (dsh_reg >> 1);
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    case (job_reg)
                        J_HL:
                        begin
                            hl_next    = eng_q[24:0];
                            state_next = S_LM0;
                        end
                        J_LIM:
                        begin
                            lim_next   = eng_q[StepW-1:0];
                            state_next = S_LL;
                        end
                        J_LEN:
                        begin
                            len_next   = eng_q[24:0];
                            k_next     = '0;
                            state_next = S_SCM;
                        end
                        J_SC:
                        begin
                            tgt_next[k_reg] = scale_tgt(pos_reg[k_reg], dneg_reg[k_reg],
                                                        eng_q[CoordW-1:0]);
                            if (k_reg == 2'd2)
                            begin
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = S_SCM;
                            end
                        end
                        J_AVG:
                        begin
                            av = acc_reg[k_reg][ACCW-1] ? -$signed(eng_q[24:0])
                                                        : $signed(eng_q[24:0]);
                            res_next[k_reg] = clamp_axis(av, cfg.lower[k_reg],
                                                         cfg.upper[k_reg]);
                            if (k_reg == 2'd2)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = S_AVG;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_HL;
            k_reg         <= '0;
            tap_reg       <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            k_reg         <= k_next;
            tap_reg       <= tap_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        tgt_reg  <= tgt_next;
        res_reg  <= res_next;
        safe_reg <= safe_next;
        dabs_reg <= dabs_next;
        dneg_reg <= dneg_next;
        sum_reg  <= sum_next;
        tsq_reg  <= tsq_next;
        hl_reg   <= hl_next;
        len_reg  <= len_next;
        lim_reg  <= lim_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        acc_reg  <= acc_next;
        vneg_reg <= vneg_next;
    end
endmodule

// ===== hw/rtl/setpoint_step_limit_fade_clamp_top.sv =====
// top level: configuration registers, stream ports and the limiter core
//
// Takes one request on the s_ channel: current position and requested goal,
// six signed Q16 coordinates. Returns one request on the m_ channel: the
// step limited, history averaged and box clamped setpoint, three coordinates.
// Configuration is written over cfg_we / cfg_index / cfg_data; the user must
// write it only while idle, the block itself does not enforce this. One request
// is worked on at a time; s_tready is high only while idle. The shared
// compare-subtract unit runs each square root and each divide one result bit
// per cycle, and the history memory read port walks the taps one at a time.
// The result sits in an output register; a stalled receiver holds m_tdata
// and m_tvalid, and the core parks finished work until that register frees.
// Reset loads the register defaults and empties the history; memory contents
// are not cleared, the fill count masks them.
module setpoint_step_limit_fade_clamp_top #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // pos_x, pos_y, pos_z, goal_x, goal_y, goal_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // safe_x, safe_y, safe_z
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);
    import ssl_pkg::*;

    cfg_t cfg_reg, cfg_next;
    coord_t [2:0] safe;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_XY: cfg_next.max_xy   = cfg_data[StepW-1:0];
                REG_MAX_Z:  cfg_next.max_z    = cfg_data[StepW-1:0];
                REG_X_UP:   cfg_next.upper[0] = cfg_data;
                REG_Y_UP:   cfg_next.upper[1] = cfg_data;
                REG_Z_UP:   cfg_next.upper[2] = cfg_data;
                REG_X_LO:   cfg_next.lower[0] = cfg_data;
                REG_Y_LO:   cfg_next.lower[1] = cfg_data;
                REG_Z_LO:   cfg_next.lower[2] = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_xy <= 23'd65536;
            cfg_reg.max_z  <= 23'd32768;
            for (int i = 0; i < 3; i++)
            begin
                cfg_reg.upper[i] <= CoordMax;
                cfg_reg.lower[i] <= CoordMin;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssl_core #(.DEPTH(HISTORY_DEPTH)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos       (s_tdata[71:0]),
        .goal      (s_tdata[143:72]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .safe      (safe)
    );

    assign m_tdata = safe;
endmodule

// ===== hw/rtl/ssl_check.sv =====
// port level checks for the setpoint limiter, bound to the top level
module ssl_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);
    // busy after taking a request
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after a request was taken");

    // no result the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after a request");

    // a new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while the block was idle");

    // stalled result holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");
endmodule

bind setpoint_step_limit_fade_clamp_top ssl_check u_ssl_check (.*);
